FILE: hdl/skf_pkg.sv
// Shared types and constants for the seen-key tree filter.
// Used by the controller, the datapath, the top level and the checker.
package skf_pkg;

	localparam int KEY_W    = 64;
	localparam int STATUS_W = 2;
	localparam int ROT_R    = 9;
	localparam int DEV_SHL  = 13;

	// Result codes
	localparam logic [STATUS_W-1:0] ST_NEW  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SEEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic                load_item;  // capture pair and key, point at root
		logic                clear_used; // empty the tree
		logic                latch_dir;  // remember which way the walk turned
		logic                step;       // follow the child link
		logic                write_node; // fill next free node, links empty
		logic                write_link; // hook new node under its parent
		logic                bump_used;  // count the new node
		logic                load_out;   // load result register
		logic [STATUS_W-1:0] code;       // result code for load_out
	} skf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic used_zero;
		logic pool_full;
		logic pair_match;
		logic next_zero;
	} skf_sts_t;

	function automatic logic [KEY_W-1:0] make_key(input logic [KEY_W-1:0] dev,
		input logic [KEY_W-1:0] ino);
		logic [KEY_W-1:0] rot;
		rot = (ino >> ROT_R) | (ino << (KEY_W - ROT_R));
		return rot + (dev << DEV_SHL);
	endfunction

endpackage

FILE: hdl/skf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module skf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/skf_ctrl.sv
// Controller state machine for the seen-key tree filter: handshakes and
// sequencing of the tree walk. Depends on skf_pkg.
module skf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              action,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  skf_pkg::skf_sts_t sts,
	output skf_pkg::skf_cmd_t cmd
);
	import skf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_LINK = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [STATUS_W-1:0] code_q, code_d;
	logic                out_valid_q;
	logic                out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					if (action) begin
						cmd.clear_used = 1'b1;
						code_d  = ST_NEW;
						state_d = S_RESP;
					end else if (sts.used_zero) begin
						state_d = S_INS;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.pair_match) begin
					code_d  = ST_SEEN;
					state_d = S_RESP;
				end else begin
					cmd.latch_dir = 1'b1;
					if (!sts.next_zero) begin
						cmd.step = 1'b1;
						state_d  = S_READ;
					end else if (sts.pool_full) begin
						code_d  = ST_FULL;
						state_d = S_RESP;
					end else begin
						state_d = S_INS;
					end
				end
			end
			S_INS: begin
				cmd.write_node = 1'b1;
				if (sts.used_zero) begin
					cmd.bump_used = 1'b1;
					code_d  = ST_NEW;
					state_d = S_RESP;
				end else begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				cmd.write_link = 1'b1;
				cmd.bump_used  = 1'b1;
				code_d  = ST_NEW;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, pending code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_NEW;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/skf_dp.sv
// Datapath for the seen-key tree filter: key, walk pointer, node count,
// node memories and result register. Depends on skf_pkg and skf_ram.
module skf_dp #(
	parameter int POOL_NODES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [skf_pkg::KEY_W-1:0]     device_id,
	input  logic [skf_pkg::KEY_W-1:0]     inode_id,
	input  skf_pkg::skf_cmd_t             cmd,
	output skf_pkg::skf_sts_t             sts,
	output logic [skf_pkg::STATUS_W-1:0]  status
);
	import skf_pkg::*;

	localparam int IDX_W  = $clog2(POOL_NODES);
	localparam int CNT_W  = $clog2(POOL_NODES + 1);
	localparam int NODE_W = 3 * KEY_W;

	logic [KEY_W-1:0]    dev_q, ino_q, key_q;
	logic [IDX_W-1:0]    cur_q;
	logic [CNT_W-1:0]    used_q;
	logic                go_right_q;
	logic [STATUS_W-1:0] status_q;

	logic [IDX_W-1:0]  new_idx;
	logic [NODE_W-1:0] node_rd;
	logic [KEY_W-1:0]  node_dev, node_ino, node_key;
	logic [IDX_W-1:0]  left_rd, right_rd, next_idx;
	logic              go_right;
	logic              left_we, right_we;
	logic [IDX_W-1:0]  left_wa, right_wa, left_wd, right_wd;

	assign new_idx = used_q[IDX_W-1:0];
	assign {node_dev, node_ino, node_key} = node_rd;

	// Compare against the node just read and pick the child
	assign go_right = key_q > node_key;
	assign next_idx = go_right ? right_rd : left_rd;

	assign sts.used_zero  = (used_q == '0);
	assign sts.pool_full  = (used_q == CNT_W'(POOL_NODES));
	assign sts.pair_match = (node_dev == dev_q) && (node_ino == ino_q);
	assign sts.next_zero  = (next_idx == '0);

	// Link writes: clear both links of a new node, or hook it under the parent
	assign left_we  = cmd.write_node || (cmd.write_link && !go_right_q);
	assign right_we = cmd.write_node || (cmd.write_link && go_right_q);
	assign left_wa  = cmd.write_node ? new_idx : cur_q;
	assign right_wa = cmd.write_node ? new_idx : cur_q;
	assign left_wd  = cmd.write_node ? '0 : new_idx;
	assign right_wd = cmd.write_node ? '0 : new_idx;

	skf_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_node_ram (
		.clk   (clk),
		.we    (cmd.write_node),
		.waddr (new_idx),
		.wdata ({dev_q, ino_q, key_q}),
		.raddr (cur_q),
		.rdata (node_rd)
	);

	skf_ram #(.WIDTH(IDX_W), .DEPTH(POOL_NODES)) u_left_ram (
		.clk   (clk),
		.we    (left_we),
		.waddr (left_wa),
		.wdata (left_wd),
		.raddr (cur_q),
		.rdata (left_rd)
	);

	skf_ram #(.WIDTH(IDX_W), .DEPTH(POOL_NODES)) u_right_ram (
		.clk   (clk),
		.we    (right_we),
		.waddr (right_wa),
		.wdata (right_wd),
		.raddr (cur_q),
		.rdata (right_rd)
	);

	// Capture the beat and hold walk state
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			dev_q <= device_id;
			ino_q <= inode_id;
			key_q <= make_key(device_id, inode_id);
		end
		if (cmd.load_item) begin
			cur_q <= '0;
		end else if (cmd.step) begin
			cur_q <= next_idx;
		end
		if (cmd.latch_dir) begin
			go_right_q <= go_right;
		end
		if (cmd.load_out) begin
			status_q <= cmd.code;
		end
	end

	// Node count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clear_used) begin
			used_q <= '0;
		end else if (cmd.bump_used) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	assign status = status_q;

endmodule

FILE: hdl/seen_key_tree_filter.sv
// Seen-key tree filter: remembers (device, inode) pairs in a binary search
// tree held in a node pool of POOL_NODES entries.
// Request channel: req_valid/req_ready with action, device_id, inode_id.
//   action 0 checks the pair and inserts it if absent; action 1 empties
//   the tree. Response channel: rsp_valid/rsp_ready with status
//   (0 new or cleared, 1 already seen, 2 pool full, nothing changed).
// One beat is in flight at a time. A clear goes straight to the response
// state once accepted. A check walks the tree from the root, then an insert
// at the root takes S_INS only and one below it S_INS and S_LINK: each level
// costs one registered read of the node memory (S_READ) and one compare (S_CMP).
// The result register lets the next request be taken while a response
// still waits; if the receiver stalls longer, the block holds the finished
// result and waits before loading the next one.
// Reset empties the tree at once (node count to zero); node memories are
// never cleared, since only nodes below the count are read.
module seen_key_tree_filter #(
	parameter int POOL_NODES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         action,
	input  logic [skf_pkg::KEY_W-1:0]    device_id,
	input  logic [skf_pkg::KEY_W-1:0]    inode_id,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [skf_pkg::STATUS_W-1:0] status
);
	import skf_pkg::*;

	skf_cmd_t cmd;
	skf_sts_t sts;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skf_dp #(.POOL_NODES(POOL_NODES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.device_id (device_id),
		.inode_id  (inode_id),
		.cmd       (cmd),
		.sts       (sts),
		.status    (status)
	);

endmodule

FILE: hdl/skf_checker.sv
// Port-level checks for the seen-key tree filter, bound to the top level.
// Depends on skf_pkg.
module skf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         action,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [skf_pkg::STATUS_W-1:0] status
);
	import skf_pkg::*;

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("stalled response changed");

	// Never report an unused code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_NEW || status == ST_SEEN || status == ST_FULL))
		else $error("unused status code");

	// Take one request at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Answer a clear with new, through the response state, when the output is free
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && action && !rsp_valid |=> ##1
		rsp_valid && status == ST_NEW)
		else $error("clear not answered");

endmodule

bind seen_key_tree_filter skf_checker u_skf_checker (.*);
